// ===== hdl/ppsu_pkg.sv =====
// Shared types and status codes for the priority scheduler cell chain.
package ppsu_pkg;

  localparam logic [1:0] STATUS_LOAD_OK  = 2'd0;
  localparam logic [1:0] STATUS_LOAD_REJ = 2'd1;
  localparam logic [1:0] STATUS_RAN      = 2'd2;
  localparam logic [1:0] STATUS_IDLE     = 2'd3;

  // Beat handed from one cell to the next during a scan.
  typedef struct packed {
    logic        tok;    // scan token, one cell at a time
    logic        found;  // best candidate held / free slot claimed
    logic [7:0]  prio;
    logic [7:0]  id;
    logic [15:0] rem;
  } chain_t;

  // Operation data broadcast to every cell.
  typedef struct packed {
    logic        is_tick;
    logic        commit;
    logic [31:0] now;
    logic [7:0]  ld_id;
    logic [15:0] ld_burst;
    logic [31:0] ld_arrival;
    logic [7:0]  ld_prio;
  } bcast_t;

endpackage

// ===== hdl/ppsu_cell.sv =====
// One process slot of the scheduler table plus its stage of the scan chain.
module ppsu_cell import ppsu_pkg::*; #(
  parameter int IDX_W    = 3,
  parameter int CELL_IDX = 0
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  bcast_t           bc_i,
  input  logic [IDX_W-1:0] commit_idx_i,
  input  chain_t           chain_i,
  input  logic [IDX_W-1:0] win_idx_i,
  output chain_t           chain_o,
  output logic [IDX_W-1:0] win_idx_o
);

  logic        valid_q, valid_d;
  logic [7:0]  id_q;
  logic [15:0] rem_q, rem_dec;
  logic [31:0] arr_q;
  logic [7:0]  prio_q;

  logic             tok_q, found_q;
  logic [7:0]       out_prio_q, out_id_q;
  logic [15:0]      out_rem_q;
  logic [IDX_W-1:0] out_idx_q;

  logic elig, take, claim, hit;

  assign elig  = bc_i.is_tick && valid_q && (arr_q <= bc_i.now);
  assign take  = chain_i.tok && elig && (!chain_i.found || (prio_q > chain_i.prio));
  // first free slot on the way takes the load
  assign claim = chain_i.tok && !bc_i.is_tick && !chain_i.found && !valid_q &&
                 (bc_i.ld_burst != 16'd0);
  assign hit   = bc_i.commit && (commit_idx_i == IDX_W'(CELL_IDX));
  assign rem_dec = (rem_q != 16'd0) ? rem_q - 16'd1 : rem_q;

  always_comb begin
    valid_d = valid_q;
    if (claim) begin
      valid_d = 1'b1;
    end else if (hit && (rem_dec == 16'd0)) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      tok_q   <= 1'b0;
      found_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
      tok_q   <= chain_i.tok;
      found_q <= chain_i.found | take | claim;
    end
  end

  always_ff @(posedge clk_i) begin
    if (claim) begin
      id_q   <= bc_i.ld_id;
      rem_q  <= bc_i.ld_burst;
      arr_q  <= bc_i.ld_arrival;
      prio_q <= bc_i.ld_prio;
    end else if (hit) begin
      rem_q <= rem_dec;
    end
    if (take) begin
      out_prio_q <= prio_q;
      out_id_q   <= id_q;
      out_rem_q  <= rem_q;
      out_idx_q  <= IDX_W'(CELL_IDX);
    end else begin
      out_prio_q <= chain_i.prio;
      out_id_q   <= chain_i.id;
      out_rem_q  <= chain_i.rem;
      out_idx_q  <= win_idx_i;
    end
  end

  assign chain_o.tok   = tok_q;
  assign chain_o.found = found_q;
  assign chain_o.prio  = out_prio_q;
  assign chain_o.id    = out_id_q;
  assign chain_o.rem   = out_rem_q;
  assign win_idx_o     = out_idx_q;

endmodule

// ===== hdl/preemptive_priority_scheduler_unit.sv =====
// Preemptive priority scheduler: sequencer, cell chain and output register.
//
// Input beats (s_axis_*): tuser = 0 loads a process entry from tdata into the
// lowest free slot; tuser = 1 advances time by one tick, running the arrived
// entry of highest priority (lowest slot wins a tie) for one unit.
// Every input beat yields exactly one output beat (m_axis_*), in order.
//
// The table is a row of NUM_SLOTS cells. An operation sends a token down the
// row, one cell per cycle, carrying the best candidate or the load claim;
// a load is written into the free slot that the token claims, and at the end
// of a tick scan the winning cell is updated. The next beat is taken only
// after the result has been handed to the output register. s_axis_tready is
// high whenever no operation is in flight, even while a result still waits
// in the output register. If the receiver stalls, the next result waits until
// the register empties, and input is held off.
//
// Reset clears all slots and sets the time counter to zero; the block is
// ready as soon as reset is released.
module preemptive_priority_scheduler_unit import ppsu_pkg::*; #(
  parameter int NUM_SLOTS = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [7:0] proc_id, [23:8] proc_burst, [55:24] proc_arrival, [63:56] proc_priority
  input  logic [63:0] s_axis_tdata,
  // [0] req_type
  input  logic        s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [31:0] tick_time, [39:32] run_id, [55:40] run_remaining, [56] run_finished,
  // [63:57] zero
  output logic [63:0] m_axis_tdata,
  // [1:0] status
  output logic [1:0]  m_axis_tuser
);

  localparam int IDX_W = $clog2(NUM_SLOTS);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  logic [1:0]  state_q, state_d;
  logic        seed_q;
  logic        is_tick_q;
  logic [31:0] now_q;
  logic [7:0]  ld_id_q, ld_prio_q;
  logic [15:0] ld_burst_q;
  logic [31:0] ld_arr_q;

  logic [1:0]  res_status_q;
  logic [31:0] res_time_q;
  logic [7:0]  res_id_q;
  logic [15:0] res_rem_q;
  logic        res_fin_q;

  logic        out_valid_q;
  logic [63:0] out_data_q;
  logic [1:0]  out_user_q;

  chain_t           chain [NUM_SLOTS+1];
  logic [IDX_W-1:0] win   [NUM_SLOTS+1];
  logic [NUM_SLOTS-1:0] tok_vec;
  bcast_t           bc;

  logic        in_acc, scan_end, push;
  chain_t      last;
  logic [15:0] last_rem_dec;

  assign s_axis_tready = (state_q == S_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign last          = chain[NUM_SLOTS];
  assign scan_end      = (state_q == S_SCAN) && last.tok;
  assign push          = (state_q == S_DONE) && (!out_valid_q || m_axis_tready);
  assign last_rem_dec  = (last.rem != 16'd0) ? last.rem - 16'd1 : last.rem;

  assign bc.is_tick    = is_tick_q;
  assign bc.commit     = scan_end && is_tick_q && last.found;
  assign bc.now        = now_q;
  assign bc.ld_id      = ld_id_q;
  assign bc.ld_burst   = ld_burst_q;
  assign bc.ld_arrival = ld_arr_q;
  assign bc.ld_prio    = ld_prio_q;

  assign chain[0].tok   = seed_q;
  assign chain[0].found = 1'b0;
  assign chain[0].prio  = 8'd0;
  assign chain[0].id    = 8'd0;
  assign chain[0].rem   = 16'd0;
  assign win[0]         = '0;

  for (genvar k = 0; k < NUM_SLOTS; k++) begin : g_cell
    ppsu_cell #(
      .IDX_W    (IDX_W),
      .CELL_IDX (k)
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .bc_i         (bc),
      .commit_idx_i (win[NUM_SLOTS]),
      .chain_i      (chain[k]),
      .win_idx_i    (win[k]),
      .chain_o      (chain[k+1]),
      .win_idx_o    (win[k+1])
    );
    assign tok_vec[k] = chain[k+1].tok;
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:  if (in_acc) state_d = S_SCAN;
      S_SCAN:  if (last.tok) state_d = S_DONE;
      S_DONE:  if (push) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      seed_q      <= 1'b0;
      now_q       <= 32'd0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      seed_q  <= in_acc;
      if (scan_end && is_tick_q) begin
        now_q <= now_q + 32'd1;
      end
      if (push) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      is_tick_q  <= s_axis_tuser;
      ld_id_q    <= s_axis_tdata[7:0];
      ld_burst_q <= s_axis_tdata[23:8];
      ld_arr_q   <= s_axis_tdata[55:24];
      ld_prio_q  <= s_axis_tdata[63:56];
    end
    if (scan_end) begin
      res_time_q <= 32'd0;
      res_id_q   <= 8'd0;
      res_rem_q  <= 16'd0;
      res_fin_q  <= 1'b0;
      if (!is_tick_q) begin
        res_status_q <= last.found ? STATUS_LOAD_OK : STATUS_LOAD_REJ;
      end else if (last.found) begin
        res_status_q <= STATUS_RAN;
        res_time_q   <= now_q;
        res_id_q     <= last.id;
        res_rem_q    <= last_rem_dec;
        res_fin_q    <= (last_rem_dec == 16'd0);
      end else begin
        res_status_q <= STATUS_IDLE;
        res_time_q   <= now_q;
      end
    end
    if (push) begin
      out_data_q <= {7'd0, res_fin_q, res_rem_q, res_id_q, res_time_q};
      out_user_q <= res_status_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;

`ifndef SYNTH
  a_one_token: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({seed_q, tok_vec}))
    else $error("more than one scan token in the cell chain");

  a_token_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (seed_q || (tok_vec != '0)) |-> (state_q == S_SCAN))
    else $error("scan token outside of a scan");

  a_time_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(now_q) |-> $past(scan_end && is_tick_q))
    else $error("time counter moved without a tick");

  a_fin_matches: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (m_axis_tuser == STATUS_RAN)) |->
      (m_axis_tdata[56] == (m_axis_tdata[55:40] == 16'd0)))
    else $error("finished flag disagrees with remaining burst");

  a_accept_starts_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> (state_q == S_SCAN) && seed_q)
    else $error("accepted beat did not start a scan");
`endif

endmodule
